[src/address_lease_table_core_assert.svh]
// ----------------------------------------------------------------------------
// address lease table assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ADDRESS_LEASE_TABLE_CORE_ASSERT_SVH
`define ADDRESS_LEASE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define ALT_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("lease table check failed");

// next-cycle implication
`define ALT_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("lease table check failed");

`endif

[src/alt_pkg.sv]
// ----------------------------------------------------------------------------
// alt_pkg
// types, codes and sizes shared by the address lease table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int HW_W     = 48;
    localparam int IP_W     = 32;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam int IN_TDATA_W   = ((HW_W + IP_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + HW_W + IP_W + TIME_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [TIME_W-1:0] LEASE_RESET = TIME_W'(3600);

    localparam logic [KIND_W-1:0] KIND_LOOKUP_MAC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP_IP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [IP_W-1:0]   ip;
        logic [HW_W-1:0]   hw;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

[src/alt_ram.sv]
// ----------------------------------------------------------------------------
// alt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/address_lease_table_core.sv]
// ----------------------------------------------------------------------------
// address_lease_table_core
// lease table in insertion order with lookup, expiry search, insert and delete
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tuser kind, s_tdata hw/ip/now
//   m_       out  m_tvalid/m_tready    m_tuser status, m_tdata slot/hw/ip/start
//   cfg_     in   cfg_valid/cfg_ready  cfg_data lease_duration
//
// insert, unused kind or search of an empty table: straight to ST_RESP, m_tvalid registered
// search: ST_FETCH then ST_CHECK per entry examined through the single ram read port
// delete: search, then ST_SHIFT_RD/ST_SHIFT_WR per entry moved down, ST_SHIFT_RD drops the count
// one command in flight; a pending result holds the sequencer until taken
// reset clears the entry count and loads the lease duration with 3600
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module address_lease_table_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [alt_pkg::IN_TDATA_W-1:0] s_tdata,   // hw_address, client_ip, now_seconds
    input  wire logic [alt_pkg::KIND_W-1:0]     s_tuser,   // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [alt_pkg::OUT_TDATA_W-1:0]     m_tdata,   // slot, found_hw_address, found_ip,
                                                           // found_lease_start, zero pad
    output logic [alt_pkg::STATUS_W-1:0]        m_tuser,   // status
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [alt_pkg::TIME_W-1:0]     cfg_data
);

    import alt_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [HW_W-1:0]       hw_reg, hw_next;
    logic [IP_W-1:0]       ip_reg, ip_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [TIME_W-1:0]     lease_reg;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    entry_t                res_entry_reg, res_entry_next;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    entry_t                ram_wr_data;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    entry_t                ram_rd_data;

    logic                  in_xfer;
    logic                  out_free;
    logic                  hit;
    logic [TIME_W-1:0]     age;
    logic [CNT_W-1:0]      idx_plus1;
    entry_t                in_entry;

    alt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign in_entry  = '{start: s_tdata[HW_W+IP_W +: TIME_W],
                         ip:    s_tdata[HW_W +: IP_W],
                         hw:    s_tdata[HW_W-1:0]};

    // shared compare unit
    assign age = now_reg - ram_rd_data.start;
    always_comb begin
        case (kind_reg)
            KIND_LOOKUP_MAC, KIND_DELETE: hit = (ram_rd_data.hw == hw_reg);
            KIND_LOOKUP_IP:               hit = (ram_rd_data.ip == ip_reg);
            KIND_EXPIRED:                 hit = (age >= lease_reg);
            default:                      hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            lease_reg    <= LEASE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                lease_reg <= cfg_data;
            end
            if (state_reg == ST_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        hw_reg         <= hw_next;
        ip_reg         <= ip_next;
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_entry_reg  <= res_entry_next;
        if (state_reg == ST_RESP && out_free) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res_entry_reg.start, res_entry_reg.ip,
                            res_entry_reg.hw, res_slot_reg};
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        hw_next         = hw_reg;
        ip_next         = ip_reg;
        now_next        = now_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_entry_next  = res_entry_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    kind_next       = s_tuser;
                    hw_next         = in_entry.hw;
                    ip_next         = in_entry.ip;
                    now_next        = in_entry.start;
                    idx_next        = '0;
                    res_status_next = ST_MISS;
                    res_slot_next   = '0;
                    res_entry_next  = '0;
                    state_next      = ST_RESP;
                    case (s_tuser) inside
                        KIND_INSERT: begin
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_wr_en       = 1'b1;
                                ram_wr_addr     = count_reg[IDX_W-1:0];
                                ram_wr_data     = in_entry;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                                res_slot_next   = SLOT_W'(count_reg);
                                res_entry_next  = in_entry;
                            end
                        end
                        [KIND_LOOKUP_MAC:KIND_EXPIRED], KIND_DELETE: begin
                            if (count_reg != '0) begin
                                state_next = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                ram_rd_en  = 1'b1;
                ram_rd_addr = idx_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (hit) begin
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_W'(idx_reg);
                    res_entry_next  = ram_rd_data;
                    state_next      = (kind_reg == KIND_DELETE) ? ST_SHIFT_RD : ST_RESP;
                end else if (idx_plus1 == count_reg) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next   = idx_plus1[IDX_W-1:0];
                    state_next = ST_FETCH;
                end
            end
            ST_SHIFT_RD: begin
                if (idx_plus1 < count_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_plus1[IDX_W-1:0];
                    state_next  = ST_SHIFT_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = ram_rd_data;
                idx_next    = idx_plus1[IDX_W-1:0];
                state_next  = ST_SHIFT_RD;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`include "address_lease_table_core_assert.svh"

    `ALT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `ALT_ASSERT_NXT(a_busy_after_xfer, in_xfer, !s_tready)
    `ALT_ASSERT_IMP(a_write_in_range, ram_wr_en, CNT_W'(ram_wr_addr) <= count_reg)
    `ALT_ASSERT_NXT(a_count_step, state_reg != ST_IDLE && state_reg != ST_SHIFT_RD,
                    count_reg == $past(count_reg))

endmodule

`default_nettype wire

[sim/address_lease_table_core_test.sv]
// ----------------------------------------------------------------------------
// address_lease_table_core_test
// self-checking bench for the lease table: a queue-fed driver pushes
// lookups, expiry searches, inserts and deletes with random gaps, a shadow
// table predicts every answer, and the monitor checks each result transfer
// field by field while the lease duration is rewritten between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_lease_table_core_test;

    import alt_pkg::*;

    localparam int POOL_SIZE     = 24;
    localparam int SEGMENTS      = 17;
    localparam int SEGMENT_ITEMS = 100;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 200;

    typedef enum int {ACT_COMMAND, ACT_LEASE_WRITE, ACT_DRAIN} act_t;

    typedef struct {
        act_t              act;
        logic [KIND_W-1:0] kind;
        logic [HW_W-1:0]   hw;
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] value;
    } lease_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [HW_W-1:0]     hw;
        logic [IP_W-1:0]     ip;
        logic [TIME_W-1:0]   start;
    } lease_answer_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TIME_W-1:0]      cfg_data = '0;

    // shadow of the lease table
    logic [HW_W-1:0]   tbl_hw    [TABLE_DEPTH];
    logic [IP_W-1:0]   tbl_ip    [TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_start [TABLE_DEPTH];
    int                tbl_count = 0;
    logic [TIME_W-1:0] lease_len = LEASE_RESET;

    lease_cmd_t    command_q [$];
    lease_answer_t answer_q  [$];

    logic s_took = 1'b0;
    logic m_took = 1'b0;
    logic cfg_took = 1'b0;
    int   send_gap = 0;
    int   send_calm = 0;
    int   recv_gap = 0;
    int   recv_calm = 0;
    int   settle = 0;
    int   error_count = 0;

    address_lease_table_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic lease_answer_t lease_table_answer(logic [KIND_W-1:0] kind,
                                                         logic [HW_W-1:0] hw,
                                                         logic [IP_W-1:0] ip,
                                                         logic [TIME_W-1:0] now);
        lease_answer_t ans;
        int pos;
        logic [TIME_W-1:0] age;
        ans = '0;
        ans.status = ST_MISS;
        pos = -1;
        case (kind)
            KIND_LOOKUP_MAC, KIND_DELETE: begin
                for (int i = 0; i < tbl_count; i++)
                    if (pos < 0 && tbl_hw[i] == hw) pos = i;
            end
            KIND_LOOKUP_IP: begin
                for (int i = 0; i < tbl_count; i++)
                    if (pos < 0 && tbl_ip[i] == ip) pos = i;
            end
            KIND_EXPIRED: begin
                for (int i = 0; i < tbl_count; i++) begin
                    age = now - tbl_start[i];
                    if (pos < 0 && age >= lease_len) pos = i;
                end
            end
            KIND_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                    return ans;
                end
                pos = tbl_count;
                tbl_hw[pos] = hw;
                tbl_ip[pos] = ip;
                tbl_start[pos] = now;
                tbl_count++;
            end
            default: ;
        endcase
        if (pos >= 0) begin
            ans.status = ST_OK;
            ans.slot = pos[SLOT_W-1:0];
            ans.hw = tbl_hw[pos];
            ans.ip = tbl_ip[pos];
            ans.start = tbl_start[pos];
            if (kind == KIND_DELETE) begin
                for (int i = pos; i + 1 < tbl_count; i++) begin
                    tbl_hw[i] = tbl_hw[i + 1];
                    tbl_ip[i] = tbl_ip[i + 1];
                    tbl_start[i] = tbl_start[i + 1];
                end
                tbl_count--;
            end
        end
        return ans;
    endfunction

    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [HW_W-1:0] rand_hw();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[HW_W-1:0];
    endfunction

    task automatic add_command(logic [KIND_W-1:0] kind, logic [HW_W-1:0] hw,
                               logic [IP_W-1:0] ip, logic [TIME_W-1:0] now);
        lease_cmd_t c;
        c.act = ACT_COMMAND;
        c.kind = kind;
        c.hw = hw;
        c.ip = ip;
        c.now = now;
        c.value = '0;
        command_q.push_back(c);
    endtask

    task automatic add_marker(act_t act, logic [TIME_W-1:0] value);
        lease_cmd_t c;
        c.act = act;
        c.kind = '0;
        c.hw = '0;
        c.ip = '0;
        c.now = '0;
        c.value = value;
        command_q.push_back(c);
    endtask

    task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        error_count++;
    endtask

    // monitor and shadow update, sampled at the rising edge
    always @(posedge aclk) begin
        lease_answer_t want;
        s_took <= aresetn && s_tvalid && s_tready;
        m_took <= aresetn && m_tvalid && m_tready;
        cfg_took <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) lease_len = cfg_data;
            if (s_tvalid && s_tready)
                answer_q.push_back(lease_table_answer(s_tuser, s_tdata[47:0],
                                                      s_tdata[79:48], s_tdata[111:80]));
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    note_mismatch("unexpected result", 64'(m_tuser), 64'd0);
                end else begin
                    want = answer_q.pop_front();
                    if (m_tuser != want.status)
                        note_mismatch("status", 64'(m_tuser), 64'(want.status));
                    if (m_tdata[3:0] != want.slot)
                        note_mismatch("slot", 64'(m_tdata[3:0]), 64'(want.slot));
                    if (m_tdata[51:4] != want.hw)
                        note_mismatch("found_hw_address", 64'(m_tdata[51:4]), 64'(want.hw));
                    if (m_tdata[83:52] != want.ip)
                        note_mismatch("found_ip", 64'(m_tdata[83:52]), 64'(want.ip));
                    if (m_tdata[115:84] != want.start)
                        note_mismatch("found_lease_start", 64'(m_tdata[115:84]),
                                      64'(want.start));
                end
            end
        end
    end

    // command and lease register driver
    always @(negedge aclk) begin
        logic next_valid;
        logic next_cfg;
        if (aresetn) begin
            next_valid = s_tvalid && !s_took;
            next_cfg = cfg_valid && !cfg_took;
            if (answer_q.size() == 0 && !s_tvalid && !cfg_valid) settle++;
            else settle = 0;
            if (!next_valid && !next_cfg) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (command_q.size() != 0) begin
                    case (command_q[0].act)
                        ACT_COMMAND: begin
                            s_tuser <= command_q[0].kind;
                            s_tdata <= {command_q[0].now, command_q[0].ip, command_q[0].hw};
                            next_valid = 1'b1;
                            void'(command_q.pop_front());
                            send_gap = draw_gap(send_calm);
                        end
                        ACT_LEASE_WRITE: begin
                            if (settle >= SETTLE_CYCLES) begin
                                cfg_data <= command_q[0].value;
                                next_cfg = 1'b1;
                                void'(command_q.pop_front());
                            end
                        end
                        default: begin
                            if (answer_q.size() == 0) void'(command_q.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid <= next_valid;
            cfg_valid <= next_cfg;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took) recv_gap = draw_gap(recv_calm);
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [HW_W-1:0]   hw_pool [POOL_SIZE];
        logic [IP_W-1:0]   ip_pool [POOL_SIZE];
        logic [TIME_W-1:0] wall;
        logic [TIME_W-1:0] lease;
        logic [TIME_W-1:0] step;
        logic [KIND_W-1:0] kind;
        int                r;
        int                ins_pct;
        int                del_pct;

        hw_pool[0] = '0;
        hw_pool[1] = '1;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            hw_pool[i] = rand_hw();
            ip_pool[i] = $urandom;
        end

        // empty table, fill to the top, full, first-match and expiry corners
        add_command(KIND_LOOKUP_MAC, hw_pool[2], ip_pool[2], 32'd0);
        add_command(KIND_EXPIRED, '1, '1, '1);
        add_command(KIND_DELETE, hw_pool[1], '0, '0);
        add_command(KIND_INSERT, '0, '0, '0);
        add_command(KIND_INSERT, '1, '1, '1);
        add_command(KIND_INSERT, '1, 32'd1, 32'd100);
        for (int i = 3; i < TABLE_DEPTH; i++)
            add_command(KIND_INSERT, hw_pool[i], ip_pool[i], 32'd200 + i);
        add_command(KIND_INSERT, hw_pool[20], ip_pool[20], 32'd300);
        add_command(KIND_LOOKUP_MAC, hw_pool[TABLE_DEPTH-1], '0, '0);
        add_command(KIND_LOOKUP_IP, '0, ip_pool[TABLE_DEPTH-1], '0);
        add_command(KIND_LOOKUP_IP, '1, 32'd1, '0);
        add_command(KIND_EXPIRED, '0, '0, 32'd3599);
        add_command(KIND_EXPIRED, '0, '0, 32'd3600);
        add_command(3'd5, '1, '1, '1);
        add_command(3'd6, '0, '0, '0);
        add_command(3'd7, hw_pool[4], ip_pool[4], 32'd7);
        add_command(KIND_DELETE, '0, '0, '0);
        add_command(KIND_DELETE, '1, '0, '0);
        add_command(KIND_DELETE, hw_pool[TABLE_DEPTH-1], '0, '0);
        add_command(KIND_LOOKUP_MAC, hw_pool[TABLE_DEPTH-1], '0, '0);
        add_marker(ACT_LEASE_WRITE, '0);
        add_command(KIND_EXPIRED, '0, '0, 32'd0);
        add_marker(ACT_LEASE_WRITE, '1);
        add_command(KIND_EXPIRED, '0, '0, 32'd99);

        wall = 32'd5000;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: lease = 32'd1;
                1: lease = '1;
                2: lease = '0;
                3: lease = LEASE_RESET;
                default: begin
                    case ($urandom_range(0, 5))
                        0: lease = LEASE_RESET;
                        1: lease = 32'd1;
                        2: lease = $urandom_range(2, 60);
                        3: lease = '1;
                        4: lease = '0;
                        default: lease = $urandom;
                    endcase
                end
            endcase
            add_marker(ACT_LEASE_WRITE, lease);
            step = (lease < 64) ? lease / 3 + 2 : ((lease <= 100000) ? lease / 6 : 1000);
            case (seg % 3)
                0: begin ins_pct = 55; del_pct = 10; end
                1: begin ins_pct = 10; del_pct = 45; end
                default: begin ins_pct = 30; del_pct = 20; end
            endcase
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                if (seg == SEGMENTS / 2 && n == SEGMENT_ITEMS / 2) add_marker(ACT_DRAIN, '0);
                r = $urandom_range(0, 99);
                if (r < 3) kind = KIND_W'($urandom_range(5, 7));
                else if (r < 3 + ins_pct) kind = KIND_INSERT;
                else if (r < 3 + ins_pct + del_pct) kind = KIND_DELETE;
                else kind = KIND_W'($urandom_range(0, 2));
                r = $urandom_range(0, 99);
                if (r < 2) wall = $urandom;
                else if (r < 6) wall = wall - $urandom_range(1, 8);
                else wall = wall + $urandom_range(0, step);
                add_command(kind,
                            ($urandom_range(0, 9) == 0) ? rand_hw()
                                : hw_pool[$urandom_range(0, POOL_SIZE - 1)],
                            ($urandom_range(0, 9) == 0) ? $urandom
                                : ip_pool[$urandom_range(0, POOL_SIZE - 1)],
                            wall);
            end
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (command_q.size() != 0 || s_tvalid || cfg_valid) @(posedge aclk);
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
